/* rtl/core/tvi32_pkg.sv */
// tvi32_pkg: types, codes and constants for the tagged value to int32 unit
// no dependencies
package tvi32_pkg;

  localparam int KindW = 3;
  localparam int PayloadW = 64;
  localparam int WordW = 32;
  localparam int ExpW = 11;
  localparam int MantW = 53;

  typedef enum logic [KindW-1:0] {
    KIND_INT32   = 3'd0,
    KIND_UINT32  = 3'd1,
    KIND_FLOAT64 = 3'd2,
    KIND_BOOLEAN = 3'd3,
    KIND_OBJECT  = 3'd4
  } kind_t;

  localparam logic [ExpW-1:0] EXP_ALL_ONES = 11'h7ff;
  localparam logic [ExpW-1:0] EXP_BIAS_UNIT = 11'd1023;
  localparam logic [ExpW-1:0] EXP_INT_POINT = 11'd1075;

  typedef struct packed {
    logic [WordW-1:0] result_word;
    logic             is_undefined;
  } result_t;

  // truncate a double toward zero and wrap modulo 2^32
  function automatic logic [WordW-1:0] double_to_word(input logic [PayloadW-1:0] bits);
    logic [ExpW-1:0]  expo;
    logic [MantW-1:0] mant;
    logic [ExpW-1:0]  sh;
    logic [WordW-1:0] mag;
    expo = bits[62:52];
    mant = {1'b1, bits[51:0]};
    mag = '0;
    if (expo == EXP_ALL_ONES || expo < EXP_BIAS_UNIT) begin
      mag = '0;
    end else if (expo >= EXP_INT_POINT) begin
      sh = expo - EXP_INT_POINT;
      if (sh >= 11'd32) begin
        mag = '0;
      end else begin
        mag = WordW'(mant << sh[4:0]);
      end
    end else begin
      sh = EXP_INT_POINT - expo;
      mag = WordW'(mant >> sh[5:0]);
    end
    if (bits[63]) begin
      mag = WordW'(0) - mag;
    end
    return mag;
  endfunction

endpackage

/* rtl/core/tvi32_if.sv */
// tvi32_if: valid/ready channels for input items and result items
// depends on tvi32_pkg
interface tvi32_in_if;
  logic                             valid;
  logic                             ready;
  logic [tvi32_pkg::KindW-1:0]      kind;
  logic [tvi32_pkg::PayloadW-1:0]   payload;
  modport source (output valid, kind, payload, input ready);
  modport sink (input valid, kind, payload, output ready);
endinterface

interface tvi32_out_if;
  logic                          valid;
  logic                          ready;
  logic [tvi32_pkg::WordW-1:0]   result_word;
  logic                          is_undefined;
  modport source (output valid, result_word, is_undefined, input ready);
  modport sink (input valid, result_word, is_undefined, output ready);
endinterface

/* rtl/core/tagged_value_to_int32_wrap_unit.sv */
// tagged_value_to_int32_wrap_unit: tagged script value to 32-bit word
// registered path: input register, then result register
// throughput one item per cycle; a stalled result holds the input register
// reset clears valid bits only; payload registers are not reset
// depends on tvi32_pkg and tvi32_if
module tagged_value_to_int32_wrap_unit (
  input logic clk,
  input logic rst_n,
  tvi32_in_if.sink in_ch,
  tvi32_out_if.source out_ch
);

  logic                             in_vld_r;
  logic [tvi32_pkg::KindW-1:0]      kind_r;
  logic [tvi32_pkg::PayloadW-1:0]   payload_r;
  logic                             out_vld_r;
  tvi32_pkg::result_t               res_r;
  tvi32_pkg::result_t               res_nxt;
  logic                             adv;

  assign adv = !out_vld_r || out_ch.ready;
  assign in_ch.ready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ch.ready) in_vld_r <= in_ch.valid;
      if (adv) out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      kind_r <= in_ch.kind;
      payload_r <= in_ch.payload;
    end
    if (adv && in_vld_r) res_r <= res_nxt;
  end

  always_comb begin
    res_nxt.result_word = '0;
    res_nxt.is_undefined = 1'b0;
    case (kind_r)
      tvi32_pkg::KIND_INT32, tvi32_pkg::KIND_UINT32: begin
        res_nxt.result_word = payload_r[31:0];
      end
      tvi32_pkg::KIND_FLOAT64: begin
        res_nxt.result_word = tvi32_pkg::double_to_word(payload_r);
      end
      tvi32_pkg::KIND_BOOLEAN: begin
        res_nxt.result_word = {31'd0, |payload_r[31:0]};
      end
      default: begin
        res_nxt.is_undefined = 1'b1;
      end
    endcase
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.result_word = res_r.result_word;
  assign out_ch.is_undefined = res_r.is_undefined;

  // undefined items carry a zero word
  a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.is_undefined |-> res_r.result_word == '0)
    else $error("undefined item with nonzero word");

  // a stalled result is not overwritten
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |=> out_vld_r && $stable(res_r))
    else $error("stalled result changed");

  // boolean items give 0 or 1
  a_bool: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_vld_r && kind_r == tvi32_pkg::KIND_BOOLEAN |=> res_r.result_word[31:1] == '0)
    else $error("boolean result out of range");

endmodule

/* tb/sv/tb_tagged_value_to_int32_wrap_unit.sv */
// testbench for tagged_value_to_int32_wrap_unit: drives tagged values, predicts the int32 word
// and undefined flag for each, and compares every result item in order
// depends on tvi32_pkg, tvi32_if and the unit itself
module tb_tagged_value_to_int32_wrap_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [tvi32_pkg::KindW-1:0]    kind;
    logic [tvi32_pkg::PayloadW-1:0] payload;
  } value_t;

  logic clk = 1'b0;
  logic rst_n;

  tvi32_in_if  in_ch ();
  tvi32_out_if out_ch ();

  tagged_value_to_int32_wrap_unit dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  value_t                pending_values[$];
  tvi32_pkg::result_t    expected_words[$];
  int                    send_idle_pct;
  int                    recv_idle_pct;
  bit                    hold_sender;
  bit                    timed_out;
  int                    failures;
  int                    values_sent;
  int                    words_seen;
  int                    quiet_cycles;
  int                    kind_hits[8];

  localparam int QuietLimit = 20000;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // truncate toward zero and wrap modulo 2^32
  function automatic logic [tvi32_pkg::WordW-1:0] wrap_double(
      logic [tvi32_pkg::PayloadW-1:0] bits);
    int unsigned      e;
    logic [63:0]      m;
    logic [63:0]      mag;
    e = 32'(bits[62:52]);
    m = {11'd0, 1'b1, bits[51:0]};
    if (e == 2047 || e < 1023) return '0;
    if (e >= 1075) begin
      mag = (e - 1075 >= 32) ? 64'd0 : (m << (e - 1075));
    end else begin
      mag = m >> (1075 - e);
    end
    mag = mag & 64'hffff_ffff;
    if (bits[63]) mag = (64'd0 - mag) & 64'hffff_ffff;
    return mag[31:0];
  endfunction

  function automatic tvi32_pkg::result_t convert_value(value_t v);
    tvi32_pkg::result_t r;
    r.result_word = '0;
    r.is_undefined = 1'b0;
    case (v.kind)
      tvi32_pkg::KIND_INT32, tvi32_pkg::KIND_UINT32: r.result_word = v.payload[31:0];
      tvi32_pkg::KIND_FLOAT64: r.result_word = wrap_double(v.payload);
      tvi32_pkg::KIND_BOOLEAN: r.result_word = (v.payload[31:0] != 0) ? 32'd1 : 32'd0;
      default:                 r.is_undefined = 1'b1;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // doubles biased toward the interesting exponent band around the integer point
  function automatic logic [63:0] rand_double();
    logic [63:0] b;
    int          sel;
    b = rand64();
    sel = $urandom_range(0, 9);
    if (sel < 6) b[62:52] = 11'($urandom_range(1015, 1115));
    else if (sel == 6) b[62:52] = 11'h7ff;
    else if (sel == 7) b[62:52] = 11'($urandom_range(0, 2));
    return b;
  endfunction

  task automatic add_value(logic [tvi32_pkg::KindW-1:0] k,
                           logic [tvi32_pkg::PayloadW-1:0] p);
    value_t v;
    v.kind = k;
    v.payload = p;
    pending_values.push_back(v);
  endtask

  task automatic wait_drained();
    while (pending_values.size() != 0 || in_ch.valid || expected_words.size() != 0)
      @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.kind <= '0;
      in_ch.payload <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        expected_words.push_back(convert_value('{in_ch.kind, in_ch.payload}));
        kind_hits[in_ch.kind]++;
        values_sent++;
      end
      if (!hold_sender && pending_values.size() != 0 &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        value_t v;
        v = pending_values.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.kind <= v.kind;
        in_ch.payload <= v.payload;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        tvi32_pkg::result_t want;
        words_seen++;
        if (expected_words.size() == 0) begin
          failures++;
          $display("%0t: unexpected result word=%h undef=%b", $time,
                   out_ch.result_word, out_ch.is_undefined);
        end else begin
          want = expected_words.pop_front();
          if (out_ch.result_word !== want.result_word) begin
            failures++;
            $display("%0t: result_word expected %h actual %h", $time,
                     want.result_word, out_ch.result_word);
          end
          if (out_ch.is_undefined !== want.is_undefined) begin
            failures++;
            $display("%0t: is_undefined expected %b actual %b", $time,
                     want.is_undefined, out_ch.is_undefined);
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= QuietLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("timeout after %0d idle cycles", quiet_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int phase;
    int n;
    rst_n = 1'b0;
    send_idle_pct = 27;
    recv_idle_pct = 76;
    hold_sender = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // integer kinds, booleans, objects and unused codes
    add_value(tvi32_pkg::KIND_INT32, 64'hffff_ffff_8000_0000);
    add_value(tvi32_pkg::KIND_UINT32, 64'h0000_0000_ffff_ffff);
    add_value(tvi32_pkg::KIND_INT32, 64'h0);
    add_value(tvi32_pkg::KIND_BOOLEAN, 64'hffff_ffff_0000_0000);
    add_value(tvi32_pkg::KIND_BOOLEAN, 64'h0000_0000_0000_0001);
    add_value(tvi32_pkg::KIND_OBJECT, 64'hffff_ffff_ffff_ffff);
    add_value(3'd5, 64'h1234);
    add_value(3'd7, 64'hffff_ffff_ffff_ffff);
    // doubles: nan, negative infinity, negative zero, subnormal, below one, big, wrapping
    add_value(tvi32_pkg::KIND_FLOAT64, 64'h7ff8_0000_0000_0000);
    add_value(tvi32_pkg::KIND_FLOAT64, 64'hfff0_0000_0000_0000);
    add_value(tvi32_pkg::KIND_FLOAT64, 64'h8000_0000_0000_0000);
    add_value(tvi32_pkg::KIND_FLOAT64, 64'h0000_0000_0000_0001);
    add_value(tvi32_pkg::KIND_FLOAT64, 64'hbfef_ffff_ffff_ffff);
    add_value(tvi32_pkg::KIND_FLOAT64, 64'h3ff0_0000_0000_0000);
    add_value(tvi32_pkg::KIND_FLOAT64, 64'hbff8_0000_0000_0000);
    add_value(tvi32_pkg::KIND_FLOAT64, 64'h41e0_0000_0000_0000);
    add_value(tvi32_pkg::KIND_FLOAT64, 64'h41ef_ffff_ffe0_0000);
    add_value(tvi32_pkg::KIND_FLOAT64, 64'h41f0_0000_0000_0000);
    add_value(tvi32_pkg::KIND_FLOAT64, 64'hc1f0_0000_1000_0000);
    add_value(tvi32_pkg::KIND_FLOAT64, 64'h4330_0000_0000_0001);
    add_value(tvi32_pkg::KIND_FLOAT64, 64'h4350_0000_0000_0003);
    add_value(tvi32_pkg::KIND_FLOAT64, 64'h7fef_ffff_ffff_ffff);

    for (phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        wait_drained();
        hold_sender = 1'b1;
        repeat (5) @(posedge clk);
        hold_sender = 1'b0;
        send_idle_pct = 76;
        recv_idle_pct = 27;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (n = 0; n < 260; n++) begin
        int s;
        s = $urandom_range(0, 9);
        if (s < 5) add_value(tvi32_pkg::KIND_FLOAT64, rand_double());
        else if (s < 9) add_value(3'($urandom_range(0, 3)), rand64());
        else add_value(3'($urandom_range(4, 7)), rand64());
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    $display("converted %0d values: int32 %0d uint32 %0d float64 %0d bool %0d other %0d",
             values_sent, kind_hits[0], kind_hits[1], kind_hits[2], kind_hits[3],
             kind_hits[4] + kind_hits[5] + kind_hits[6] + kind_hits[7]);
    $display("%0d result items checked under three stall profiles", words_seen);
    if (failures == 0 && expected_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
